// ===== rtl/core/masked_area_resample_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the masked area resampler
// Short forms of the concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MASKED_AREA_RESAMPLE_ASSERT_SVH
`define MASKED_AREA_RESAMPLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MAR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/mar_pkg.sv =====
// ----------------------------------------------------------------------------
// mar_pkg
// Shared constants and types of the masked area resampler.
// ----------------------------------------------------------------------------
package mar_pkg;
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_SPAN   = 16;
    localparam int CFG_W          = 9;
    localparam int POS_W          = 16;
    localparam int SPAN_W         = 13;
    localparam int PIX_W          = 8;
    localparam logic [7:0] PIX_MAX = 8'd255;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Request from the sequencer to the divider. The weight total of a
    // window of up to 8191 by 8191 256ths-of-a-pixel needs 26 bits.
    typedef struct packed
    {
        logic        start;
        logic [47:0] num;
        logic [25:0] den;
    } div_req_t;
endpackage

// ===== rtl/core/masked_area_resample.sv =====
// ----------------------------------------------------------------------------
// masked_area_resample
// Masked area-averaging resampler over a stored 8-bit image.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    func, pix_*, x_pos .. y_span
// out       output     out_valid_o / out_ready out_value, out_valid
// cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// A sample visits every cell of its window one per cycle through the single
// read port of the pixel memory, then passes through the pipeline tail and
// the bit-serial divider, presents its result and goes back to idle.
// Reset clears the control state only; pixel contents are undefined until
// written. A result waits in the output register while the consumer stalls,
// and a new request is taken only once it has gone.
// ----------------------------------------------------------------------------
module masked_area_resample
#(
    parameter int MAX_WIDTH  = mar_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mar_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SPAN   = mar_pkg::DEF_MAX_SPAN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  pix_col,
    input  logic [7:0]  pix_row,
    input  logic [7:0]  pix_value,
    input  logic        pix_valid,
    input  logic [15:0] x_pos,
    input  logic [15:0] y_pos,
    input  logic [12:0] x_span,
    input  logic [12:0] y_span,
    output logic        out_valid_o,
    input  logic        out_ready,
    output logic [7:0]  out_value,
    output logic        out_valid,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);
    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW = CW + RW;
    localparam int SPAN_LIMIT = MAX_SPAN * 256;

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_DIV, S_OUT } state_t;

    state_t      state_reg;
    logic [8:0]  img_w_reg, img_h_reg;
    // Window, as cell indices (Q8.8 edges kept for the overlap).
    logic [16:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [8:0]  c_reg, r_reg, c_first_reg, c_last_reg, r_last_reg;
    logic [8:0]  wlim_reg, hlim_reg;
    // Stage after memory read.
    logic        p_act_reg;
    logic [16:0] p_w_reg;
    logic        scan_end_reg, tail_reg;
    logic [25:0] wsum_reg;
    logic [33:0] vsum_reg;
    logic [7:0]  res_val_reg;
    logic        res_vld_reg;

    logic [12:0] sx, sy;
    logic [16:0] x1n, y1n;
    logic [8:0]  rdata;
    logic [AW-1:0] raddr, waddr;
    logic        we;
    logic [8:0]  ov_x, ov_y;
    logic [16:0] ca, cb, ra, rb, ax, bx, ay, by;
    logic        in_bounds;
    logic        issue;
    mar_pkg::div_req_t dreq;
    logic        ddone;
    logic [7:0]  dquot;

    assign in_ready = (state_reg == S_IDLE);
    assign sx = (32'(x_span) > SPAN_LIMIT) ? 13'(SPAN_LIMIT) : x_span;
    assign sy = (32'(y_span) > SPAN_LIMIT) ? 13'(SPAN_LIMIT) : y_span;
    assign x1n = {1'b0, x_pos} + 17'(sx);
    assign y1n = {1'b0, y_pos} + 17'(sy);

    // A cell address goes to the memory on every scan cycle until the last
    // cell of the window has been issued.
    assign issue = (state_reg == S_SCAN) && !scan_end_reg && !tail_reg;

    // Pixel writes outside the store are dropped.
    assign we = in_valid && in_ready && func == mar_pkg::FUNC_WRITE
        && 32'(pix_col) < MAX_WIDTH && 32'(pix_row) < MAX_HEIGHT;
    assign waddr = {RW'(pix_row), CW'(pix_col)};
    assign raddr = {RW'(r_reg), CW'(c_reg)};

    mar_store #(.AW(AW)) u_store
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata ({pix_valid, pix_value}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Overlap of the current cell with the window along each axis.
    always_comb
    begin
        ca = {c_reg, 8'd0};
        cb = {c_reg, 8'd0} + 17'd256;
        ax = (ca < x0_reg) ? x0_reg : ca;
        bx = (cb > x1_reg) ? x1_reg : cb;
        ov_x = (bx > ax) ? 9'(bx - ax) : 9'd0;
        ra = {r_reg, 8'd0};
        rb = {r_reg, 8'd0} + 17'd256;
        ay = (ra < y0_reg) ? y0_reg : ra;
        by = (rb > y1_reg) ? y1_reg : rb;
        ov_y = (by > ay) ? 9'(by - ay) : 9'd0;
        in_bounds = c_reg < wlim_reg && r_reg < hlim_reg;
    end

    always_comb
    begin
        dreq.start = tail_reg;
        dreq.num   = 48'(vsum_reg);
        dreq.den   = wsum_reg;
    end

    mar_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (ddone),
        .quot  (dquot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            img_w_reg    <= 9'd256;
            img_h_reg    <= 9'd256;
            p_act_reg    <= 1'b0;
            scan_end_reg <= 1'b0;
            tail_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mar_pkg::REG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                    mar_pkg::REG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                    default: ;
                endcase
            end
            // The read data of an issued cell is valid in the next cycle; the
            // cycle after the last cell's data is the tail that starts the
            // divider.
            p_act_reg    <= issue;
            scan_end_reg <= issue && c_reg == c_last_reg && r_reg == r_last_reg;
            tail_reg     <= (state_reg == S_SCAN) && scan_end_reg;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && func == mar_pkg::FUNC_SAMPLE)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (tail_reg)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (ddone)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE)
        begin
            x0_reg      <= {1'b0, x_pos};
            y0_reg      <= {1'b0, y_pos};
            x1_reg      <= x1n;
            y1_reg      <= y1n;
            c_reg       <= {1'b0, x_pos[15:8]};
            r_reg       <= {1'b0, y_pos[15:8]};
            c_first_reg <= {1'b0, x_pos[15:8]};
            c_last_reg  <= x1n[16:8];
            r_last_reg  <= y1n[16:8];
            wlim_reg    <= (32'(img_w_reg) < MAX_WIDTH)  ? img_w_reg : 9'(MAX_WIDTH);
            hlim_reg    <= (32'(img_h_reg) < MAX_HEIGHT) ? img_h_reg : 9'(MAX_HEIGHT);
            wsum_reg    <= '0;
            vsum_reg    <= '0;
        end
        else if (state_reg == S_SCAN)
        begin
            if (issue)
            begin
                // Weight of this cell, used when its data returns.
                p_w_reg <= (in_bounds) ? 17'(ov_x * ov_y) : 17'd0;
                if (c_reg == c_last_reg)
                begin
                    c_reg <= c_first_reg;
                    r_reg <= r_reg + 9'd1;
                end
                else
                begin
                    c_reg <= c_reg + 9'd1;
                end
            end
            if (p_act_reg && rdata[8])
            begin
                wsum_reg <= wsum_reg + 26'(p_w_reg);
                vsum_reg <= vsum_reg + 34'(25'(p_w_reg) * 25'(rdata[7:0]));
            end
        end
        if (state_reg == S_DIV && ddone)
        begin
            res_vld_reg <= (wsum_reg != 26'd0);
            res_val_reg <= (wsum_reg != 26'd0) ? dquot : 8'd0;
        end
    end

    assign out_valid_o = (state_reg == S_OUT);
    assign out_value   = res_val_reg;
    assign out_valid   = res_vld_reg;
endmodule

// ===== rtl/core/mar_div.sv =====
// ----------------------------------------------------------------------------
// mar_div
// Restoring divider, one quotient bit a cycle, 8-bit saturated quotient.
// ----------------------------------------------------------------------------
module mar_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  mar_pkg::div_req_t req,
    output logic              done,
    output logic [7:0]        quot
);
    // The quotient saturates at 255, so only nine quotient bits are needed:
    // the numerator is first compared against den << 8.
    logic [3:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic [47:0] rem_reg,  rem_next;
    logic [25:0] den_reg,  den_next;
    logic [8:0]  q_reg,    q_next;
    logic [47:0] trial;
    logic [3:0]  sh;

    always_comb
    begin
        sh = 4'd8 - cnt_reg;
        trial = 48'(den_reg) << sh;
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done      = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            rem_next  = req.num;
            den_next  = req.den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                q_next   = {q_reg[7:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[7:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd8)
            begin
                busy_next = 1'b0;
            end
        end
        if (busy_reg == 1'b0 && cnt_reg == 4'd9)
        begin
            done = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 4'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= (done) ? 4'd0 : cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quot = (q_reg[8]) ? mar_pkg::PIX_MAX : q_reg[7:0];
endmodule

// ===== rtl/core/mar_store.sv =====
// ----------------------------------------------------------------------------
// mar_store
// Synchronous pixel memory, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mar_store
#(
    parameter int AW = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [8:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [8:0]    rdata
);
    logic [8:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/mar_checker.sv =====
// ----------------------------------------------------------------------------
// mar_checker
// Port-level checks of the masked area resampler.
// ----------------------------------------------------------------------------
`include "masked_area_resample_assert.svh"
module mar_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid_o,
    input logic       out_ready,
    input logic [7:0] out_value,
    input logic       out_valid
);
    `MAR_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid_o, !in_ready, "input open")
    `MAR_ASSERT_IMPL(a_zero_invalid, clk, rst_n, out_valid_o && !out_valid, out_value == 8'd0, "nonzero")
    `MAR_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_o && !out_ready, out_valid_o && $stable(out_value), "dropped")
    `MAR_ASSERT_NEXT(a_ready_after, clk, rst_n, out_valid_o && out_ready, in_ready, "not ready")
endmodule

bind masked_area_resample mar_checker u_mar_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid_o (out_valid_o),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_valid   (out_valid)
);
